// ----- sv/bbsa_pkg.sv -----
package bbsa_pkg;

  // Table geometry and capacities
  localparam int SLOT_COUNT      = 128;
  localparam int VERTEX_CAPACITY = 1024;
  localparam int INDEX_CAPACITY  = 4096;
  localparam int OWNER_COUNT     = 4;

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  // fills must also hold an oversized first grant, so never narrower than the request
  localparam int VFILL_W = ($clog2(VERTEX_CAPACITY) > 10) ? $clog2(VERTEX_CAPACITY) : 10;
  localparam int IFILL_W = ($clog2(INDEX_CAPACITY) > 12) ? $clog2(INDEX_CAPACITY) : 12;
  localparam int TAG_W   = 3;
  localparam int KEY_W   = 16;

  // Request modes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_ENUM  = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  // Response status codes
  localparam logic [2:0] ST_APPEND  = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_NONE    = 3'd2;
  localparam logic [2:0] ST_CLEARED = 3'd3;
  localparam logic [2:0] ST_FOUND   = 3'd4;

  // One slot table entry as stored in RAM
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [KEY_W-1:0]   key;
    logic [VFILL_W-1:0] vfill;
    logic [IFILL_W-1:0] ifill;
  } entry_t;

  // Per-entry verdict from the evaluation unit
  typedef struct packed {
    logic               is_free;
    logic               owned;
    logic               hit;
    logic [VFILL_W:0]   vsum;
    logic [IFILL_W:0]   isum;
  } eval_t;

endpackage

// ----- sv/bbsa_ram.sv -----
module bbsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/bbsa_eval.sv -----
module bbsa_eval (
  input  bbsa_pkg::entry_t                 ent,
  input  logic                             ent_valid,
  input  logic [bbsa_pkg::TAG_W-1:0]       tag,
  input  logic [bbsa_pkg::KEY_W-1:0]       key,
  input  logic [bbsa_pkg::VFILL_W-1:0]     vreq,
  input  logic [bbsa_pkg::IFILL_W-1:0]     ireq,
  output bbsa_pkg::eval_t                  ev
);

  logic vroom;
  logic iroom;

  always_comb begin
    ev.vsum    = {1'b0, ent.vfill} + {1'b0, vreq};
    ev.isum    = {1'b0, ent.ifill} + {1'b0, ireq};
    // room means the sum stays strictly below capacity
    vroom      = 32'(ev.vsum) < bbsa_pkg::VERTEX_CAPACITY;
    iroom      = 32'(ev.isum) < bbsa_pkg::INDEX_CAPACITY;
    ev.is_free = !ent_valid || (ent.tag == '0);
    ev.owned   = ent_valid && (ent.tag == tag);
    ev.hit     = ev.owned && (ent.key == key) && vroom && iroom;
  end

endmodule

// ----- sv/batch_buffer_slot_allocator_top.sv -----
// Allocate scans the slots from slot 0 between accept and response: one slot is read and
//   evaluated per cycle, then the chosen entry, if any, is written to the slot RAM.
// Enumerate scans from start_slot; clear and rejects go straight to the response state.
// Throughput: one request at a time; the scan of the single-port slot RAM sets the rate.
// Reset (rst, synchronous): all slots free, no response pending, ready for a request.
module batch_buffer_slot_allocator_top (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  mode,
  input  logic [1:0]  owner,
  input  logic [15:0] material_key,
  input  logic [9:0]  vertex_request,
  input  logic [11:0] index_request,
  input  logic [6:0]  start_slot,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [6:0]  slot,
  output logic [9:0]  vertex_base,
  output logic [11:0] index_base
);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;

  // Latched request
  logic [1:0]                       req_mode;
  logic [bbsa_pkg::TAG_W-1:0]       req_tag;
  logic [bbsa_pkg::KEY_W-1:0]       req_key;
  logic [bbsa_pkg::VFILL_W-1:0]     req_vreq;
  logic [bbsa_pkg::IFILL_W-1:0]     req_ireq;

  // Scan pipeline: issue stage (rd_*) and evaluate stage (e_*)
  logic [bbsa_pkg::SLOT_W-1:0]      rd_idx;
  logic                             rd_last;
  logic                             iss_done;
  logic                             e_vld;
  logic [bbsa_pkg::SLOT_W-1:0]      e_idx;
  logic                             e_last;
  logic                             ent_valid;
  logic                             have_free;
  logic [bbsa_pkg::SLOT_W-1:0]      free_idx;

  // Per-slot occupancy; a slot whose bit is low reads as free
  logic [bbsa_pkg::SLOT_COUNT-1:0]  slot_valid;

  // Pending write
  logic [bbsa_pkg::SLOT_W-1:0]      wr_idx;
  bbsa_pkg::entry_t                 wr_data;
  logic                             wr_new;

  // Result waiting for the output register
  logic [2:0]                       res_status;
  logic [bbsa_pkg::SLOT_W-1:0]      res_slot;
  logic [9:0]                       res_vb;
  logic [11:0]                      res_ib;

  // RAM port and evaluation unit
  logic                             ram_we;
  logic [bbsa_pkg::SLOT_W-1:0]      ram_addr;
  bbsa_pkg::entry_t                 ram_rdata;
  bbsa_pkg::eval_t                  ev;

  assign req_stall = (state != S_IDLE);
  assign rd_last   = (32'(rd_idx) == bbsa_pkg::SLOT_COUNT - 1);
  assign ram_we    = (state == S_WRITE);
  assign ram_addr  = ram_we ? wr_idx : rd_idx;

  bbsa_ram #(
    .WIDTH ($bits(bbsa_pkg::entry_t)),
    .DEPTH (bbsa_pkg::SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wr_data),
    .rdata (ram_rdata)
  );

  // Single compare/add unit, reused for every slot of the scan
  bbsa_eval u_eval (
    .ent       (ram_rdata),
    .ent_valid (ent_valid),
    .tag       (req_tag),
    .key       (req_key),
    .vreq      (req_vreq),
    .ireq      (req_ireq),
    .ev        (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      slot_valid <= '0;
      e_vld      <= 1'b0;
      iss_done   <= 1'b0;
      have_free  <= 1'b0;
      wr_new     <= 1'b0;
    end else begin
      // S_DONE drives the output register itself
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_mode  <= mode;
            req_tag   <= bbsa_pkg::TAG_W'(owner) + 1'b1;
            req_key   <= material_key;
            req_vreq  <= bbsa_pkg::VFILL_W'(vertex_request);
            req_ireq  <= bbsa_pkg::IFILL_W'(index_request);
            have_free <= 1'b0;
            iss_done  <= 1'b0;
            e_vld     <= 1'b0;
            wr_new    <= 1'b0;
            res_slot  <= '0;
            res_vb    <= '0;
            res_ib    <= '0;
            priority if (mode == bbsa_pkg::MODE_CLEAR) begin
              slot_valid <= '0;
              res_status <= bbsa_pkg::ST_CLEARED;
              state      <= S_DONE;
            end else if (mode == bbsa_pkg::MODE_RSVD ||
                         32'(owner) >= bbsa_pkg::OWNER_COUNT) begin
              res_status <= bbsa_pkg::ST_NONE;
              state      <= S_DONE;
            end else if (mode == bbsa_pkg::MODE_ENUM &&
                         32'(start_slot) >= bbsa_pkg::SLOT_COUNT) begin
              res_status <= bbsa_pkg::ST_NONE;
              state      <= S_DONE;
            end else begin
              rd_idx <= (mode == bbsa_pkg::MODE_ENUM) ? bbsa_pkg::SLOT_W'(start_slot) : '0;
              state  <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // issue stage: one RAM read per cycle
          e_vld     <= !iss_done;
          e_idx     <= rd_idx;
          e_last    <= rd_last;
          ent_valid <= slot_valid[rd_idx];
          if (!iss_done) begin
            if (rd_last) begin
              iss_done <= 1'b1;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end

          // evaluate stage
          if (e_vld) begin
            if (req_mode == bbsa_pkg::MODE_ALLOC) begin
              if (ev.hit) begin
                res_status    <= bbsa_pkg::ST_APPEND;
                res_slot      <= e_idx;
                res_vb        <= ram_rdata.vfill[9:0];
                res_ib        <= ram_rdata.ifill[11:0];
                wr_idx        <= e_idx;
                wr_data.tag   <= req_tag;
                wr_data.key   <= req_key;
                wr_data.vfill <= ev.vsum[bbsa_pkg::VFILL_W-1:0];
                wr_data.ifill <= ev.isum[bbsa_pkg::IFILL_W-1:0];
                state         <= S_WRITE;
              end else begin
                if (ev.is_free && !have_free) begin
                  have_free <= 1'b1;
                  free_idx  <= e_idx;
                end
                if (e_last) begin
                  if (have_free || ev.is_free) begin
                    // new slot: lowest free one, no capacity check
                    res_status    <= bbsa_pkg::ST_NEW;
                    res_slot      <= have_free ? free_idx : e_idx;
                    wr_idx        <= have_free ? free_idx : e_idx;
                    wr_new        <= 1'b1;
                    wr_data.tag   <= req_tag;
                    wr_data.key   <= req_key;
                    wr_data.vfill <= req_vreq;
                    wr_data.ifill <= req_ireq;
                    state         <= S_WRITE;
                  end else begin
                    res_status <= bbsa_pkg::ST_NONE;
                    state      <= S_DONE;
                  end
                end
              end
            end else begin
              if (ev.owned) begin
                res_status <= bbsa_pkg::ST_FOUND;
                res_slot   <= e_idx;
                res_vb     <= ram_rdata.vfill[9:0];
                res_ib     <= ram_rdata.ifill[11:0];
                state      <= S_DONE;
              end else if (e_last) begin
                res_status <= bbsa_pkg::ST_NONE;
                state      <= S_DONE;
              end
            end
          end
        end

        S_WRITE: begin
          if (wr_new) begin
            slot_valid[wr_idx] <= 1'b1;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          // hand off once the output register is free or draining
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid   <= 1'b1;
            status      <= res_status;
            slot        <= 7'(res_slot);
            vertex_base <= res_vb;
            index_base  <= res_ib;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/bbsa_checker.sv -----
module bbsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [2:0]  status,
  input logic [6:0]  slot,
  input logic [9:0]  vertex_base,
  input logic [11:0] index_base
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot))
    else $error("stalled response changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= bbsa_pkg::ST_FOUND)
    else $error("unknown status code");

  // none and cleared carry no slot or bases
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == bbsa_pkg::ST_NONE || status == bbsa_pkg::ST_CLEARED)
    |-> slot == '0 && vertex_base == '0 && index_base == '0)
    else $error("nonzero fields on empty response");

  // a fresh slot always starts at offset zero
  a_new_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == bbsa_pkg::ST_NEW |-> vertex_base == '0 && index_base == '0)
    else $error("new slot with nonzero base");

endmodule

bind batch_buffer_slot_allocator_top bbsa_checker u_bbsa_checker (.*);
